// ===== rtl/core/swsa_pkg.sv =====
// Shared types, constants and arithmetic helpers of the swerve wheel speed and angle block.
package swsa_pkg;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_INVERSE_MASS     = 2'd0,
		REG_WHEELBASE_LENGTH = 2'd1,
		REG_TRACK_WIDTH      = 2'd2
	} cfg_reg_t;

	localparam int CfgIdxW     = 2;
	localparam int CordicSteps = 16;
	localparam int SqrtSteps   = 32;
	localparam int FrontLat    = 5;
	localparam int WheelLat    = SqrtSteps + 3;
	localparam int TotalLat    = FrontLat + WheelLat;
	localparam int AngDelay    = SqrtSteps - CordicSteps - 1;
	localparam int ZW          = 28;
	localparam int CW          = 36;

	localparam logic signed [ZW-1:0] PiZ        = 28'sd52707179;
	localparam logic signed [ZW-1:0] AngleLimit = 28'sd25736;
	localparam logic [31:0]          SpeedMax   = 32'h7FFF_FFFF;
	localparam logic [31:0]          InitOne    = 32'h0001_0000;

	// Arctangent of 2^-i in units of 2^-24 rad
	function automatic logic signed [ZW-1:0] atan_lut(input int i);
		logic signed [ZW-1:0] r;
		case (i)
			0:       r = 28'sd13176795;
			1:       r = 28'sd7778716;
			2:       r = 28'sd4110060;
			3:       r = 28'sd2086331;
			4:       r = 28'sd1047214;
			5:       r = 28'sd524117;
			6:       r = 28'sd262123;
			7:       r = 28'sd131069;
			8:       r = 28'sd65536;
			9:       r = 28'sd32768;
			10:      r = 28'sd16384;
			11:      r = 28'sd8192;
			12:      r = 28'sd4096;
			13:      r = 28'sd2048;
			14:      r = 28'sd1024;
			15:      r = 28'sd512;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Clamp a wide signed value to signed 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
		logic signed [31:0] r;
		if (v > 65'sh0_7FFF_FFFF)
			r = 32'sh7FFF_FFFF;
		else if (v < -65'sh0_8000_0000)
			r = 32'sh8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

// ===== rtl/core/swsa_wheel.sv =====
// One wheel: pipelined square root for speed and vectoring CORDIC for steering angle.
module swsa_wheel import swsa_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] y,
	input  logic signed [31:0] x,
	output logic [30:0]        speed,
	output logic signed [15:0] angle
);

	// stage 1: squares, magnitudes and normalizing shift
	logic [31:0]        ax, ay, m;
	logic [4:0]         msb;
	logic [4:0]         sh;
	logic [63:0]        sqy_s1, sqx_s1;
	logic signed [31:0] x_s1, y_s1;
	logic [4:0]         sh_s1;

	always_comb begin
		ax  = x[31] ? (~x + 32'd1) : x;
		ay  = y[31] ? (~y + 32'd1) : y;
		m   = (ax > ay) ? ax : ay;
		msb = '0;
		for (int i = 0; i < 30; i++) begin
			if (m[i])
				msb = 5'(i);
		end
		sh = (m[31] | m[30]) ? 5'd0 : 5'd30 - msb;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqy_s1 <= 64'($signed(y) * $signed(y));
			sqx_s1 <= 64'($signed(x) * $signed(x));
			x_s1   <= x;
			y_s1   <= y;
			sh_s1  <= sh;
		end
	end

	// stage 2: sum of squares, scale and fold into the right half plane
	logic [63:0]          rem_s  [0:SqrtSteps];
	logic [31:0]          root_s [0:SqrtSteps];
	logic signed [CW-1:0] cx_s   [0:CordicSteps];
	logic signed [CW-1:0] cy_s   [0:CordicSteps];
	logic signed [ZW-1:0] cz_s   [0:CordicSteps];
	logic signed [CW-1:0] xsc, ysc;

	always_comb begin
		xsc = CW'(x_s1) <<< sh_s1;
		ysc = CW'(y_s1) <<< sh_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= sqy_s1 + sqx_s1;
			root_s[0] <= '0;
			if (xsc < 0) begin
				cx_s[0] <= -xsc;
				cy_s[0] <= -ysc;
				cz_s[0] <= (ysc >= 0) ? PiZ : -PiZ;
			end else begin
				cx_s[0] <= xsc;
				cy_s[0] <= ysc;
				cz_s[0] <= '0;
			end
		end
	end

	// square root: one result bit per stage
	for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
		localparam int B = SqrtSteps - 1 - k;
		logic [65:0] trial;
		assign trial = ({34'd0, root_s[k]} << (B + 1)) + (66'd1 << (2 * B));
		always_ff @(posedge clk) begin
			if (en) begin
				if ({2'b00, rem_s[k]} >= trial) begin
					rem_s[k+1]  <= rem_s[k] - trial[63:0];
					root_s[k+1] <= root_s[k] | (32'd1 << B);
				end else begin
					rem_s[k+1]  <= rem_s[k];
					root_s[k+1] <= root_s[k];
				end
			end
		end
	end

	// CORDIC: one vectoring rotation per stage
	for (genvar i = 0; i < CordicSteps; i++) begin : g_cordic
		logic signed [CW-1:0] dx, dy;
		assign dx = cy_s[i] >>> i;
		assign dy = cx_s[i] >>> i;
		always_ff @(posedge clk) begin
			if (en) begin
				if (cy_s[i] >= 0) begin
					cx_s[i+1] <= cx_s[i] + dx;
					cy_s[i+1] <= cy_s[i] - dy;
					cz_s[i+1] <= cz_s[i] + atan_lut(i);
				end else begin
					cx_s[i+1] <= cx_s[i] - dx;
					cy_s[i+1] <= cy_s[i] + dy;
					cz_s[i+1] <= cz_s[i] - atan_lut(i);
				end
			end
		end
	end

	// round to Q2.13, clamp, then delay to meet the square root
	logic signed [ZW-1:0] rz;
	logic signed [15:0]   ang_s [0:AngDelay];

	assign rz = (cz_s[CordicSteps] + ZW'(1024)) >>> 11;

	always_ff @(posedge clk) begin
		if (en) begin
			if (rz > AngleLimit)
				ang_s[0] <= AngleLimit[15:0];
			else if (rz < -AngleLimit)
				ang_s[0] <= 16'(-AngleLimit);
			else
				ang_s[0] <= rz[15:0];
			for (int d = 1; d <= AngDelay; d++)
				ang_s[d] <= ang_s[d-1];
		end
	end

	// output stage: saturate speed, zero angle for a zero vector
	always_ff @(posedge clk) begin
		if (en) begin
			speed <= (root_s[SqrtSteps] > SpeedMax) ? SpeedMax[30:0] : root_s[SqrtSteps][30:0];
			angle <= (root_s[SqrtSteps] == '0) ? 16'sd0 : ang_s[AngDelay];
		end
	end

endmodule

// ===== rtl/core/swerve_wheel_speed_angle_top.sv =====
// Top level: velocity integration, wheel terms and four wheel speed/angle pipelines.
//
//  channel | handshake            | payload
//  in      | in_valid / in_ready   | forces, torque, velocities, time_step
//  out     | out_valid / out_ready| speed_* and angle_* of four wheels
//  cfg     | cfg_we               | cfg_index, cfg_wdata
//
// One word enters per cycle while the output is not stalled; the pipeline has 5 front
// stages, then 35 in each wheel, set by the 32-stage square root. Reset clears the
// valid bits and loads the registers with 1.0. A stall at the output freezes every
// stage at once; nothing is lost or repeated.
module swerve_wheel_speed_angle_top import swsa_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [31:0]         cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [31:0]  force_strafe,
	input  logic signed [31:0]  force_forward,
	input  logic signed [31:0]  restrained_torque,
	input  logic signed [31:0]  velocity_strafe,
	input  logic signed [31:0]  velocity_forward,
	input  logic signed [31:0]  angular_velocity,
	input  logic [31:0]         time_step,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [30:0]         speed_front_left,
	output logic signed [15:0]  angle_front_left,
	output logic [30:0]         speed_front_right,
	output logic signed [15:0]  angle_front_right,
	output logic [30:0]         speed_rear_left,
	output logic signed [15:0]  angle_rear_left,
	output logic [30:0]         speed_rear_right,
	output logic signed [15:0]  angle_rear_right
);

	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// configuration registers
	logic [31:0] inv_mass_q, wb_len_q, track_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_mass_q <= InitOne;
			wb_len_q   <= InitOne;
			track_q    <= InitOne;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_INVERSE_MASS:     inv_mass_q <= cfg_wdata;
				REG_WHEELBASE_LENGTH: wb_len_q   <= cfg_wdata;
				REG_TRACK_WIDTH:      track_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// valid bits travel alongside the data
	logic [TotalLat-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[TotalLat-2:0], in_valid};
	end

	assign out_valid = vld_q[TotalLat-1];

	// stage 1: acceleration = force * inverse mass
	logic signed [31:0] f_in [3];
	logic signed [31:0] v_in [3];
	logic signed [31:0] acc_s1 [3];
	logic signed [31:0] vel_s1 [3];
	logic [31:0]        dt_s1;

	always_comb begin
		f_in[0] = force_strafe;
		f_in[1] = force_forward;
		f_in[2] = restrained_torque;
		v_in[0] = velocity_strafe;
		v_in[1] = velocity_forward;
		v_in[2] = angular_velocity;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				acc_s1[k] <= sat32((65'($signed(f_in[k]) * $signed({1'b0, inv_mass_q}))) >>> 16);
				vel_s1[k] <= v_in[k];
			end
			dt_s1 <= time_step;
		end
	end

	// stage 2: velocity change = acceleration * time step
	logic signed [31:0] dv_s2  [3];
	logic signed [31:0] vel_s2 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				dv_s2[k]  <= sat32((65'($signed(acc_s1[k]) * $signed({1'b0, dt_s1}))) >>> 16);
				vel_s2[k] <= vel_s1[k];
			end
		end
	end

	// stage 3: integrated velocities
	logic signed [31:0] v_s3 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++)
				v_s3[k] <= sat32(65'(vel_s2[k]) + 65'(dv_s2[k]));
		end
	end

	// stage 4: rotation terms w*L/2 and w*W/2
	logic signed [31:0] str_s4, fwd_s4, rl_s4, rw_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			str_s4 <= v_s3[0];
			fwd_s4 <= v_s3[1];
			rl_s4  <= sat32((65'($signed(v_s3[2]) * $signed({1'b0, wb_len_q}))) >>> 17);
			rw_s4  <= sat32((65'($signed(v_s3[2]) * $signed({1'b0, track_q}))) >>> 17);
		end
	end

	// stage 5: wheel terms A, B, C, D
	logic signed [31:0] a_s5, b_s5, c_s5, d_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s5 <= sat32(65'(str_s4) - 65'(rl_s4));
			b_s5 <= sat32(65'(str_s4) + 65'(rl_s4));
			c_s5 <= sat32(65'(fwd_s4) - 65'(rw_s4));
			d_s5 <= sat32(65'(fwd_s4) + 65'(rw_s4));
		end
	end

	// per wheel speed and angle
	swsa_wheel u_fl (
		.clk(clk), .en(en), .y(b_s5), .x(d_s5),
		.speed(speed_front_left), .angle(angle_front_left)
	);

	swsa_wheel u_fr (
		.clk(clk), .en(en), .y(b_s5), .x(c_s5),
		.speed(speed_front_right), .angle(angle_front_right)
	);

	swsa_wheel u_rl (
		.clk(clk), .en(en), .y(a_s5), .x(d_s5),
		.speed(speed_rear_left), .angle(angle_rear_left)
	);

	swsa_wheel u_rr (
		.clk(clk), .en(en), .y(a_s5), .x(c_s5),
		.speed(speed_rear_right), .angle(angle_rear_right)
	);

endmodule

// ===== rtl/core/swsa_checker.sv =====
// Port-level checks of the swerve wheel speed and angle block, bound to the top level.
module swsa_checker import swsa_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [30:0]        speed_front_left,
	input logic signed [15:0] angle_front_left,
	input logic [30:0]        speed_rear_right,
	input logic signed [15:0] angle_rear_right
);

	// hold a stalled word
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(speed_front_left)
			&& $stable(angle_front_left))
		else $error("stalled output word changed");

	// keep taking input while the output is empty
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	// zero speed means a zero vector and thus a zero angle
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && speed_rear_right == '0 |-> angle_rear_right == 16'sd0)
		else $error("nonzero angle at zero speed");

	// angle stays within plus or minus pi
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> angle_front_left <= 16'(AngleLimit)
			&& angle_front_left >= 16'(-AngleLimit))
		else $error("angle out of range");

endmodule

bind swerve_wheel_speed_angle_top swsa_checker u_swsa_checker (.*);
